@@ src/stf_pkg.sv @@
// Shared types and constants of the stuffed frame receiver.
// No dependencies; used by stf_decoder and stuffed_frame_receiver.
package stf_pkg;

   localparam logic [7:0] FLAG_BYTE = 8'h5c;
   localparam logic [7:0] ESC_BYTE  = 8'h5d;
   localparam logic [7:0] ESC_MASK  = 8'h20;

   localparam logic [7:0] FRAME_ADDRESS_RESET       = 8'h01;
   localparam logic [7:0] SUPERVISORY_CONTROL_RESET = 8'h03;
   localparam logic [7:0] INFO_CONTROL_RESET        = 8'h00;

   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_ADDRESS       = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SUPERVISORY_CONTROL = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INFO_CONTROL        = 2'd2;

   typedef enum logic [2:0] {
      PH_HUNT  = 3'd0,
      PH_ADDR  = 3'd1,
      PH_CTRL  = 3'd2,
      PH_BCC1  = 3'd3,
      PH_CLOSE = 3'd4,
      PH_DATA  = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      EV_DATA  = 2'd0,
      EV_SUPER = 2'd1,
      EV_GOOD  = 2'd2,
      EV_BAD   = 2'd3
   } event_type;

   typedef struct packed {
      phase_type  phase;
      logic       is_info;
      logic       esc_pending;
      logic [7:0] held_byte;
      logic       held_valid;
      logic [7:0] check;
   } frame_state_type;

   typedef struct packed {
      logic [7:0] frame_address;
      logic [7:0] supervisory_control;
      logic [7:0] info_control;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data_byte;
      event_type  event_res;
   } result_type;

endpackage

@@ src/stf_decoder.sv @@
// Frame decoder: next frame state and result for one received byte.
// Depends on stf_pkg.
module stf_decoder (
   input  stf_pkg::frame_state_type cur_state,
   input  logic [7:0]               rx_byte,
   input  stf_pkg::cfg_type         cfg,
   output stf_pkg::frame_state_type nxt_state,
   output stf_pkg::result_type      result
);

   stf_pkg::phase_type       nxt_phase;
   stf_pkg::frame_state_type dp_state;
   logic [7:0]               sel_ctrl;
   logic [7:0]               bcc1;
   logic                     is_flag;
   logic                     do_push;
   logic [7:0]               push_val;
   logic                     frame_ok;

   assign is_flag  = (rx_byte == stf_pkg::FLAG_BYTE);
   assign sel_ctrl = cur_state.is_info ? cfg.info_control : cfg.supervisory_control;
   assign bcc1     = cfg.frame_address ^ sel_ctrl;
   assign frame_ok = cur_state.held_valid && !cur_state.esc_pending
                     && (cur_state.held_byte == cur_state.check);

   always_comb begin
      case (cur_state.phase)
         stf_pkg::PH_ADDR: begin
            if (rx_byte == cfg.frame_address) nxt_phase = stf_pkg::PH_CTRL;
            else if (is_flag)                 nxt_phase = stf_pkg::PH_ADDR;
            else                              nxt_phase = stf_pkg::PH_HUNT;
         end
         stf_pkg::PH_CTRL: begin
            if (rx_byte == cfg.supervisory_control || rx_byte == cfg.info_control)
               nxt_phase = stf_pkg::PH_BCC1;
            else if (is_flag) nxt_phase = stf_pkg::PH_ADDR;
            else              nxt_phase = stf_pkg::PH_HUNT;
         end
         stf_pkg::PH_BCC1: begin
            if (rx_byte == bcc1)
               nxt_phase = cur_state.is_info ? stf_pkg::PH_DATA : stf_pkg::PH_CLOSE;
            else if (is_flag) nxt_phase = stf_pkg::PH_ADDR;
            else              nxt_phase = stf_pkg::PH_HUNT;
         end
         stf_pkg::PH_CLOSE: nxt_phase = stf_pkg::PH_HUNT;
         stf_pkg::PH_DATA: begin
            if (is_flag) nxt_phase = stf_pkg::PH_HUNT;
            else         nxt_phase = stf_pkg::PH_DATA;
         end
         default: begin
            if (is_flag) nxt_phase = stf_pkg::PH_ADDR;
            else         nxt_phase = stf_pkg::PH_HUNT;
         end
      endcase
   end

   always_comb begin
      dp_state = cur_state;
      result   = '{valid: 1'b0, data_byte: 8'h00, event_res: stf_pkg::EV_DATA};
      do_push  = 1'b0;
      push_val = rx_byte;
      case (cur_state.phase)
         stf_pkg::PH_CTRL: begin
            if (rx_byte == cfg.supervisory_control) dp_state.is_info = 1'b0;
            else if (rx_byte == cfg.info_control)   dp_state.is_info = 1'b1;
         end
         stf_pkg::PH_BCC1: begin
            if (rx_byte == bcc1) begin
               dp_state.esc_pending = 1'b0;
               dp_state.held_byte   = 8'h00;
               dp_state.held_valid  = 1'b0;
               dp_state.check       = 8'h00;
            end
         end
         stf_pkg::PH_CLOSE: begin
            if (is_flag) begin
               result.valid     = 1'b1;
               result.event_res = stf_pkg::EV_SUPER;
            end
            dp_state = '0;
         end
         stf_pkg::PH_DATA: begin
            if (is_flag) begin
               result.valid     = 1'b1;
               result.event_res = frame_ok ? stf_pkg::EV_GOOD : stf_pkg::EV_BAD;
               dp_state         = '0;
            end else if (cur_state.esc_pending) begin
               dp_state.esc_pending = 1'b0;
               do_push              = 1'b1;
               push_val             = rx_byte ^ stf_pkg::ESC_MASK;
            end else if (rx_byte == stf_pkg::ESC_BYTE) begin
               dp_state.esc_pending = 1'b1;
            end else begin
               do_push = 1'b1;
            end
         end
         default: ;
      endcase
      // release the held byte one byte late
      if (do_push) begin
         if (cur_state.held_valid) begin
            result.valid     = 1'b1;
            result.data_byte = cur_state.held_byte;
            result.event_res = stf_pkg::EV_DATA;
            dp_state.check   = cur_state.check ^ cur_state.held_byte;
         end
         dp_state.held_byte  = push_val;
         dp_state.held_valid = 1'b1;
      end
   end

   always_comb begin
      nxt_state       = dp_state;
      nxt_state.phase = nxt_phase;
   end

endmodule

@@ src/stuffed_frame_receiver.sv @@
// Top level of the stuffed frame receiver: input register, frame state and result register.
// Depends on stf_pkg and stf_decoder.
//
// Usage:
//   req_ channel carries one received serial byte per item (req_rx_byte).
//   rsp_ channel carries zero or one result per byte: a destuffed payload
//   byte (event 0), a supervisory frame accepted (1), an information frame
//   good (2) or in error (3). Payload bytes come out one byte late, so the
//   trailing check byte is never delivered.
//   csr_ port writes frame_address (0), supervisory_control (1) and
//   info_control (2); write only while the block is idle.
// Timing:
//   A result passes through the input register and then the result
//   register. One byte per cycle is taken while the result side keeps up;
//   the input register and result register each hold one item, so a stalled
//   rsp_ready lets one more byte in before req_ready falls.
// Reset:
//   Synchronous; the receiver hunts for an opening flag, both registers are
//   empty and the configuration takes address 1, supervisory control 3 and
//   info control 0.
module stuffed_frame_receiver (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_rx_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [7:0]                          rsp_data_byte,
   output logic [1:0]                          rsp_event_res,
   input  logic                                csr_wr_en,
   input  logic [stf_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [7:0]                          csr_wdata
);

   logic                     in_valid_ff, in_valid_in;
   logic [7:0]               in_byte_ff;
   logic                     out_valid_ff, out_valid_in;
   logic [7:0]               out_data_ff;
   stf_pkg::event_type       out_event_ff;
   stf_pkg::frame_state_type state_ff;
   stf_pkg::frame_state_type state_nxt;
   stf_pkg::cfg_type         cfg_ff;
   stf_pkg::result_type      result;
   logic                     out_free;
   logic                     step;
   logic                     req_take;

   stf_decoder u_decoder (
      .cur_state (state_ff),
      .rx_byte   (in_byte_ff),
      .cfg       (cfg_ff),
      .nxt_state (state_nxt),
      .result    (result)
   );

   assign out_free  = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign out_valid_in = out_free ? (step && result.valid) : out_valid_ff;

   assign rsp_valid     = out_valid_ff;
   assign rsp_data_byte = out_data_ff;
   assign rsp_event_res = out_event_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (step) state_ff <= state_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) in_byte_ff <= req_rx_byte;
      if (step && result.valid) begin
         out_data_ff  <= result.data_byte;
         out_event_ff <= result.event_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_address       <= stf_pkg::FRAME_ADDRESS_RESET;
         cfg_ff.supervisory_control <= stf_pkg::SUPERVISORY_CONTROL_RESET;
         cfg_ff.info_control        <= stf_pkg::INFO_CONTROL_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            stf_pkg::CSR_FRAME_ADDRESS:       cfg_ff.frame_address       <= csr_wdata;
            stf_pkg::CSR_SUPERVISORY_CONTROL: cfg_ff.supervisory_control <= csr_wdata;
            stf_pkg::CSR_INFO_CONTROL:        cfg_ff.info_control        <= csr_wdata;
            default: ;
         endcase
      end
   end

   a_ev_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != stf_pkg::EV_DATA |-> rsp_data_byte == 8'h00)
      else $error("frame event carries a non-zero data byte");

   a_held_in_data: assert property (@(posedge clock) disable iff (reset)
      state_ff.held_valid || state_ff.esc_pending |-> state_ff.phase == stf_pkg::PH_DATA)
      else $error("payload state left over outside the data phase");

   a_data_is_info: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == stf_pkg::PH_DATA |-> state_ff.is_info)
      else $error("data phase entered for a supervisory frame");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("registers not empty after reset");

endmodule
